// ===== rtl/websocket_frame_deframer_defines.svh =====
// assertion macros shared by the deframer rtl
// no dependencies; each file that asserts includes this header
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while in reset
`define WSDF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled while in reset
`define WSDF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WSDF_ASSERT_IMP(lbl, ante, cons, msg)
`define WSDF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/wsdf_pkg.sv =====
// types and constants of the websocket frame deframer
// no dependencies; used by wsdf_parser and websocket_frame_deframer
`default_nettype none
package wsdf_pkg;

	typedef enum logic [2:0] {
		PH_HDR0   = 3'd0,
		PH_HDR1   = 3'd1,
		PH_EXT    = 3'd2,
		PH_DATA   = 3'd3,
		PH_CLOSED = 3'd4
	} phase_t;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_PING  = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       has_byte;
		logic       frame_end;
		logic       message_end;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/websocket_frame_deframer.sv =====
// websocket frame deframer top level: input register, parser, result register
// depends on wsdf_pkg, wsdf_parser and websocket_frame_deframer_defines.svh
//
// usage
//   s_* takes the received server byte stream, one byte per request.
//   m_* gives one result per payload byte of text, continuation and ping
//   frames, one event for an empty data or ping frame, and one close event.
//   binary, pong and reserved frames give nothing; after a close event every
//   further byte is taken and dropped until reset.
//   m_tlast marks the last result of a frame; m_tuser carries kind, has_byte
//   and message_end.
// timing
//   a byte is registered at its accept edge; its result, if any, is then
//   registered when m_tready does not stall it. throughput is 1 byte per
//   cycle without a stall, set by the parser state update (64-bit
//   remaining-length decrement and compare) in the single parser stage.
// reset and stall
//   arst_n clears the input and result valid flags and puts the parser back to
//   waiting for the first header byte. while m_tready is low and a result is
//   waiting, one more byte can be held in the input register, then s_tready
//   drops; nothing is lost.
`default_nettype none
`include "websocket_frame_deframer_defines.svh"
module websocket_frame_deframer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tlast,   // frame_end
	output logic [3:0]      m_tuser    // [1:0] kind, [2] has_byte, [3] message_end
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           advance;
	logic           res_valid;
	wsdf_pkg::res_t res;
	logic           out_valid_q;
	wsdf_pkg::res_t out_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	wsdf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.out_byte;
	assign m_tlast  = out_q.frame_end;
	assign m_tuser  = {out_q.message_end, out_q.has_byte, out_q.kind};

	`WSDF_ASSERT_NXT(a_accept_loads, s_tvalid && s_tready, valid_s1, "accepted byte not held in input register")
	`WSDF_ASSERT_NXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(byte_s1), "stalled input register changed")
	`WSDF_ASSERT_IMP(a_close_ends_frame, out_valid_q && (out_q.kind == wsdf_pkg::KIND_CLOSE), out_q.frame_end && !out_q.has_byte, "close event without frame end")

endmodule
`default_nettype wire

// ===== rtl/wsdf_parser.sv =====
// frame header and payload parser: holds the frame state, one byte per enable
// depends on wsdf_pkg and websocket_frame_deframer_defines.svh
`default_nettype none
`include "websocket_frame_deframer_defines.svh"
module wsdf_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [7:0]    rx_byte,
	output logic               res_valid,
	output wsdf_pkg::res_t     res
);

	wsdf_pkg::phase_t phase_q, phase_n;
	logic        final_q, final_n;
	logic [3:0]  opcode_q, opcode_n;
	logic [63:0] remaining_q, remaining_n;
	logic [3:0]  len_left_q, len_left_n;

	logic        len_done;
	logic        len_zero;
	logic        last;
	logic        is_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= wsdf_pkg::PH_HDR0;
			final_q     <= 1'b0;
			opcode_q    <= 4'd0;
			remaining_q <= 64'd0;
			len_left_q  <= 4'd0;
		end else if (en) begin
			phase_q     <= phase_n;
			final_q     <= final_n;
			opcode_q    <= opcode_n;
			remaining_q <= remaining_n;
			len_left_q  <= len_left_n;
		end
	end

	always_comb begin
		phase_n     = phase_q;
		final_n     = final_q;
		opcode_n    = opcode_q;
		remaining_n = remaining_q;
		len_left_n  = len_left_q;
		len_done    = 1'b0;
		len_zero    = 1'b0;
		last        = (remaining_q == 64'd1);
		is_data     = (opcode_q == wsdf_pkg::OP_TEXT) || (opcode_q == wsdf_pkg::OP_CONT);
		res_valid   = 1'b0;
		res         = '0;
		case (phase_q)
			wsdf_pkg::PH_CLOSED: begin
				res_valid = 1'b0;
			end
			wsdf_pkg::PH_HDR1: begin
				if (rx_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
					remaining_n = 64'd0;
					len_left_n  = wsdf_pkg::EXT16_BYTES;
					phase_n     = wsdf_pkg::PH_EXT;
				end else if (rx_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
					remaining_n = 64'd0;
					len_left_n  = wsdf_pkg::EXT64_BYTES;
					phase_n     = wsdf_pkg::PH_EXT;
				end else begin
					remaining_n = {57'd0, rx_byte[6:0]};
					len_left_n  = 4'd0;
					len_done    = 1'b1;
					len_zero    = (rx_byte[6:0] == 7'd0);
				end
			end
			wsdf_pkg::PH_EXT: begin
				// extended length arrives most significant byte first
				remaining_n = {remaining_q[55:0], rx_byte};
				len_left_n  = len_left_q - 4'd1;
				len_done    = (len_left_n == 4'd0);
				len_zero    = (remaining_n == 64'd0);
			end
			wsdf_pkg::PH_DATA: begin
				remaining_n = remaining_q - 64'd1;
				if (last) begin
					phase_n = wsdf_pkg::PH_HDR0;
				end
				if (opcode_q == wsdf_pkg::OP_CLOSE) begin
					if (last) begin
						phase_n        = wsdf_pkg::PH_CLOSED;
						res_valid      = 1'b1;
						res.kind       = wsdf_pkg::KIND_CLOSE;
						res.frame_end  = 1'b1;
					end
				end else if (opcode_q == wsdf_pkg::OP_PING) begin
					res_valid     = 1'b1;
					res.out_byte  = rx_byte;
					res.kind      = wsdf_pkg::KIND_PING;
					res.has_byte  = 1'b1;
					res.frame_end = last;
				end else if (is_data) begin
					res_valid       = 1'b1;
					res.out_byte    = rx_byte;
					res.kind        = wsdf_pkg::KIND_DATA;
					res.has_byte    = 1'b1;
					res.frame_end   = last;
					res.message_end = last && final_q;
				end
			end
			default: begin
				// first header byte; unused phase codes land here too
				final_n     = rx_byte[7];
				opcode_n    = rx_byte[3:0];
				remaining_n = 64'd0;
				len_left_n  = 4'd0;
				phase_n     = wsdf_pkg::PH_HDR1;
			end
		endcase

		// length complete: enter payload or finish an empty frame
		if (len_done) begin
			if (!len_zero) begin
				phase_n = wsdf_pkg::PH_DATA;
			end else if (opcode_q == wsdf_pkg::OP_CLOSE) begin
				phase_n       = wsdf_pkg::PH_CLOSED;
				res_valid     = 1'b1;
				res.kind      = wsdf_pkg::KIND_CLOSE;
				res.frame_end = 1'b1;
			end else begin
				phase_n = wsdf_pkg::PH_HDR0;
				if (opcode_q == wsdf_pkg::OP_PING) begin
					res_valid     = 1'b1;
					res.kind      = wsdf_pkg::KIND_PING;
					res.frame_end = 1'b1;
				end else if (is_data) begin
					res_valid       = 1'b1;
					res.kind        = wsdf_pkg::KIND_DATA;
					res.frame_end   = 1'b1;
					res.message_end = final_q;
				end
			end
		end
	end

	`WSDF_ASSERT_IMP(a_ext_has_count, phase_q == wsdf_pkg::PH_EXT, len_left_q != 4'd0, "extended length phase with no length bytes left")
	`WSDF_ASSERT_IMP(a_data_nonzero, phase_q == wsdf_pkg::PH_DATA, remaining_q != 64'd0, "payload phase with zero bytes remaining")
	`WSDF_ASSERT_NXT(a_closed_sticks, phase_q == wsdf_pkg::PH_CLOSED, phase_q == wsdf_pkg::PH_CLOSED, "left closed phase without reset")

endmodule
`default_nettype wire

// ===== dv/websocket_frame_deframer_test.sv =====
// self-checking testbench for websocket_frame_deframer: random server byte streams
// against a frame parser model kept in a small scoreboard class
// depends on wsdf_pkg and the deframer rtl
`default_nettype none
module websocket_frame_deframer_test;

	localparam int CLK_HALF = 6;
	localparam int TIMEOUT_CYCLES = 400_000;
	localparam int RANDOM_BYTES = 1450;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_PONG = 4'hA;

	typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

	class deframer_board;
		wsdf_pkg::phase_t phase = wsdf_pkg::PH_HDR0;
		logic fin = 1'b0;
		logic [3:0] opcode = 4'h0;
		logic [63:0] remaining = '0;
		logic [3:0] len_left = '0;
		wsdf_pkg::res_t awaited_results[$];
		int errors = 0;

		function void note_result(wsdf_pkg::res_t r);
			awaited_results.insert(awaited_results.size(), r);
		endfunction

		// whole length known: go to payload or report the empty frame
		function void close_length();
			wsdf_pkg::res_t r;
			r = '0;
			r.frame_end = 1'b1;
			if (remaining != 0) begin
				phase = wsdf_pkg::PH_DATA;
				return;
			end
			if (opcode == wsdf_pkg::OP_CLOSE) begin
				phase = wsdf_pkg::PH_CLOSED;
				r.kind = wsdf_pkg::KIND_CLOSE;
				note_result(r);
				return;
			end
			phase = wsdf_pkg::PH_HDR0;
			if (opcode == wsdf_pkg::OP_PING) begin
				r.kind = wsdf_pkg::KIND_PING;
				note_result(r);
			end else if (opcode == wsdf_pkg::OP_TEXT || opcode == wsdf_pkg::OP_CONT) begin
				r.kind = wsdf_pkg::KIND_DATA;
				r.message_end = fin;
				note_result(r);
			end
		endfunction

		function void take_rx_byte(logic [7:0] b);
			wsdf_pkg::res_t r;
			logic last;
			r = '0;
			case (phase)
				wsdf_pkg::PH_CLOSED: ;
				wsdf_pkg::PH_HDR1: begin
					if (b[6:0] == wsdf_pkg::LEN_EXT16) begin
						remaining = '0;
						len_left = wsdf_pkg::EXT16_BYTES;
						phase = wsdf_pkg::PH_EXT;
					end else if (b[6:0] == wsdf_pkg::LEN_EXT64) begin
						remaining = '0;
						len_left = wsdf_pkg::EXT64_BYTES;
						phase = wsdf_pkg::PH_EXT;
					end else begin
						remaining = {57'd0, b[6:0]};
						len_left = '0;
						close_length();
					end
				end
				wsdf_pkg::PH_EXT: begin
					remaining = {remaining[55:0], b};
					len_left = len_left - 4'd1;
					if (len_left == 0)
						close_length();
				end
				wsdf_pkg::PH_DATA: begin
					remaining = remaining - 64'd1;
					last = (remaining == 0);
					if (last)
						phase = wsdf_pkg::PH_HDR0;
					if (opcode == wsdf_pkg::OP_CLOSE) begin
						// close payload is dropped, the event rides on its last byte
						if (last) begin
							phase = wsdf_pkg::PH_CLOSED;
							r.kind = wsdf_pkg::KIND_CLOSE;
							r.frame_end = 1'b1;
							note_result(r);
						end
					end else if (opcode == wsdf_pkg::OP_PING) begin
						r.out_byte = b;
						r.kind = wsdf_pkg::KIND_PING;
						r.has_byte = 1'b1;
						r.frame_end = last;
						note_result(r);
					end else if (opcode == wsdf_pkg::OP_TEXT || opcode == wsdf_pkg::OP_CONT) begin
						r.out_byte = b;
						r.kind = wsdf_pkg::KIND_DATA;
						r.has_byte = 1'b1;
						r.frame_end = last;
						r.message_end = last && fin;
						note_result(r);
					end
				end
				default: begin
					fin = b[7];
					opcode = b[3:0];
					remaining = '0;
					len_left = '0;
					phase = wsdf_pkg::PH_HDR1;
				end
			endcase
		endfunction

		function void flag_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			end
		endfunction

		function void check_result(wsdf_pkg::res_t got);
			wsdf_pkg::res_t want;
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, expected nothing, got %p", $time, got);
				return;
			end
			want = awaited_results.pop_front();
			flag_field("out_byte", want.out_byte, got.out_byte);
			flag_field("kind", want.kind, got.kind);
			flag_field("has_byte", want.has_byte, got.has_byte);
			flag_field("frame_end", want.frame_end, got.frame_end);
			flag_field("message_end", want.message_end, got.message_end);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic [3:0] m_tuser;

	deframer_board board = new;
	int rx_bytes_sent = 0;
	int results_seen = 0;
	bit src_steady = 1'b0;
	bit sink_steady = 1'b0;
	int sink_hold = 0;
	wsdf_pkg::res_t seen;

	websocket_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	initial begin
		#(2 * CLK_HALF * TIMEOUT_CYCLES);
		$display("status: fail");
		$finish;
	end

	// result side: random stall per result, with stretches of none
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen.out_byte = m_tdata;
				seen.kind = m_tuser[1:0];
				seen.has_byte = m_tuser[2];
				seen.message_end = m_tuser[3];
				seen.frame_end = m_tlast;
				board.check_result(seen);
				results_seen++;
				if (results_seen % 64 == 0)
					sink_steady = ($urandom_range(0, 3) == 0);
				sink_hold = sink_steady ? 0 : $urandom_range(0, 13);
			end
			if (sink_hold != 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (rx_bytes_sent % 64 == 0)
			src_steady = ($urandom_range(0, 3) == 0);
		gap = src_steady ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		board.take_rx_byte(b);
		rx_bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] first, input int unsigned n,
			input len_form_t form, input logic mask);
		logic [63:0] len64;
		len64 = 64'(n);
		send_byte(first);
		case (form)
			FORM_EXT16: begin
				send_byte({mask, wsdf_pkg::LEN_EXT16});
				send_byte(len64[15:8]);
				send_byte(len64[7:0]);
			end
			FORM_EXT64: begin
				send_byte({mask, wsdf_pkg::LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(len64[i * 8 +: 8]);
			end
			default: send_byte({mask, len64[6:0]});
		endcase
		repeat (n) send_byte(8'($urandom));
	endtask

	initial begin
		int unsigned pick;
		int unsigned n;
		logic [3:0] op;
		logic [2:0] rsv;
		logic fin_bit;
		len_form_t form;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames
		send_frame({1'b1, 3'b000, wsdf_pkg::OP_TEXT}, 0, FORM_SHORT, 1'b0);
		send_frame({1'b0, 3'b000, wsdf_pkg::OP_TEXT}, 2, FORM_SHORT, 1'b1);
		send_frame({1'b1, 3'b000, wsdf_pkg::OP_CONT}, 1, FORM_EXT16, 1'b0);
		send_frame({1'b1, 3'b000, wsdf_pkg::OP_PING}, 0, FORM_SHORT, 1'b0);
		send_frame({1'b1, 3'b000, wsdf_pkg::OP_PING}, 1, FORM_SHORT, 1'b0);
		send_frame({1'b1, 3'b111, OP_BINARY}, 1, FORM_SHORT, 1'b0);
		send_frame({1'b1, 3'b000, OP_PONG}, 0, FORM_SHORT, 1'b0);
		send_frame(8'h0F, 0, FORM_SHORT, 1'b0);
		send_frame(8'hFF, 0, FORM_SHORT, 1'b1);

		// random frames, mostly data and ping
		while (rx_bytes_sent < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			fin_bit = 1'($urandom);
			rsv = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'b000;
			if (pick < 35)
				op = wsdf_pkg::OP_TEXT;
			else if (pick < 55)
				op = wsdf_pkg::OP_CONT;
			else if (pick < 70)
				op = wsdf_pkg::OP_PING;
			else if (pick < 80)
				op = $urandom_range(0, 1) ? OP_BINARY : OP_PONG;
			else begin
				op = 4'($urandom);
				if (op == wsdf_pkg::OP_CLOSE)
					op = wsdf_pkg::OP_TEXT;
				rsv = 3'($urandom);
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				form = FORM_SHORT;
				n = $urandom_range(0, 12);
			end else if (pick < 80) begin
				form = FORM_SHORT;
				n = $urandom_range(0, 125);
			end else if (pick < 90) begin
				form = FORM_EXT16;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 300)
					: $urandom_range(0, 40);
			end else begin
				form = FORM_EXT64;
				n = $urandom_range(0, 20);
			end
			send_frame({fin_bit, rsv, op}, n, form, 1'($urandom));
		end

		// close ends the stream, later bytes are dropped
		send_frame({1'b1, 3'b000, wsdf_pkg::OP_CLOSE}, $urandom_range(0, 3), FORM_SHORT,
			1'($urandom));
		repeat (6) send_byte(8'($urandom));
		s_tvalid <= 1'b0;

		while (board.awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/wsdf_pkg.sv
rtl/wsdf_parser.sv
rtl/websocket_frame_deframer.sv
dv/websocket_frame_deframer_test.sv
